>>> design/rbf_kernel_inference_assert.svh
// ---------------------------------------------------------------------------
// rbf kernel inference assertion macros
// shared property forms for the rbf kernel inference block
// ---------------------------------------------------------------------------
`ifndef RBF_KERNEL_INFERENCE_ASSERT_SVH
`define RBF_KERNEL_INFERENCE_ASSERT_SVH

// same-cycle implication
`define RBFK_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBFK_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rbfk_pkg.sv
// ---------------------------------------------------------------------------
// rbfk_pkg
// shared constants, commands and control types of the rbf kernel block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbfk_pkg;

    localparam int DEF_MAX_CENTERS     = 64;
    localparam int DEF_MAX_DIM         = 16;
    localparam int DEF_EXP_TABLE_DEPTH = 1024;

    localparam int COORD_W   = 16;
    localparam int WEIGHT_W  = 32;
    localparam int SCORE_W   = 40;
    localparam int GAMMA_W   = 16;
    localparam int NC_W      = 7;
    localparam int DIM_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int K_W       = 17;

    // exp(-1/64) in q0.32
    localparam logic [31:0] EXP_STEP_Q32 = 32'd4228380000;

    // issue to accumulator update
    localparam int PIPE_LAT = 6;

    localparam logic [1:0] CMD_CENTER = 2'd0;
    localparam logic [1:0] CMD_WEIGHT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GAMMA       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CENTERS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIMENSION   = 2'd2;

    localparam logic [GAMMA_W-1:0] GAMMA_RST = 16'd256;
    localparam logic [NC_W-1:0]    NC_RST    = 7'd1;
    localparam logic [DIM_W-1:0]   DIM_RST   = 5'd1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } rbfk_state_t;

    typedef struct packed {
        logic load;
        logic acc_clear;
        logic issue;
        logic first_coord;
        logic last_coord;
        logic zero_dist;
        logic tab_we;
    } rbfk_ctl_t;

    typedef struct packed {
        logic [NC_W-1:0]  num_centers;
        logic [DIM_W-1:0] dimension;
    } rbfk_stat_t;

endpackage

>>> design/rbfk_ctrl.sv
// ---------------------------------------------------------------------------
// rbfk_ctrl
// sequencer: table fill, item load, center and coordinate walk, result strobe
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rbf_kernel_inference_assert.svh"

module rbfk_ctrl
    import rbfk_pkg::*;
#(
    parameter int MAX_CENTERS     = DEF_MAX_CENTERS,
    parameter int MAX_DIM         = DEF_MAX_DIM,
    parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            cmd,
    input  logic                  last,
    input  rbfk_stat_t            stat,
    output logic                  busy,
    output logic                  result_valid,
    output rbfk_ctl_t             ctl,
    output logic [(MAX_CENTERS > 1 ? $clog2(MAX_CENTERS) : 1)-1:0] c_idx,
    output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0]         j_idx,
    output logic [$clog2(EXP_TABLE_DEPTH)-1:0]                     tab_addr
);

    localparam int CIW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int JW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int TAW = $clog2(EXP_TABLE_DEPTH);
    localparam int NCW = $clog2(MAX_CENTERS + 1);
    localparam int DMW = $clog2(MAX_DIM + 1);

    rbfk_state_t     state_reg, state_next;
    logic [CIW-1:0]  c_reg, c_next;
    logic [JW-1:0]   j_reg, j_next;
    logic [TAW-1:0]  tab_cnt_reg, tab_cnt_next;
    logic [2:0]      drain_reg, drain_next;
    logic [NCW-1:0]  nc_eff;
    logic [DMW-1:0]  dim_eff;

    always_comb
    begin
        if (int'(stat.num_centers) > MAX_CENTERS)
            nc_eff = NCW'(MAX_CENTERS);
        else
            nc_eff = NCW'(stat.num_centers);
        if (int'(stat.dimension) > MAX_DIM)
            dim_eff = DMW'(MAX_DIM);
        else
            dim_eff = DMW'(stat.dimension);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            c_reg       <= '0;
            j_reg       <= '0;
            tab_cnt_reg <= '0;
            drain_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            c_reg       <= c_next;
            j_reg       <= j_next;
            tab_cnt_reg <= tab_cnt_next;
            drain_reg   <= drain_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        c_next       = c_reg;
        j_next       = j_reg;
        tab_cnt_next = tab_cnt_reg;
        drain_next   = drain_reg;
        ctl          = '0;
        result_valid = 1'b0;
        busy         = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_INIT:
            begin
                ctl.tab_we   = 1'b1;
                tab_cnt_next = tab_cnt_reg + 1'b1;
                if (tab_cnt_reg == TAW'(EXP_TABLE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    if (cmd == CMD_QUERY && last)
                    begin
                        ctl.acc_clear = 1'b1;
                        c_next        = '0;
                        j_next        = '0;
                        drain_next    = '0;
                        if (nc_eff == '0)
                            state_next = ST_DRAIN;
                        else
                            state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                ctl.issue       = 1'b1;
                ctl.first_coord = (j_reg == '0);
                ctl.zero_dist   = (dim_eff == '0);
                ctl.last_coord  = (dim_eff == '0) || (DMW'(j_reg) + DMW'(1) == dim_eff);
                if (ctl.last_coord)
                begin
                    j_next = '0;
                    if (NCW'(c_reg) + NCW'(1) == nc_eff)
                        state_next = ST_DRAIN;
                    else
                        c_next = c_reg + 1'b1;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 3'(PIPE_LAT - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                result_valid = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign c_idx    = c_reg;
    assign j_idx    = j_reg;
    assign tab_addr = tab_cnt_reg;

    `RBFK_ASSERT_NXT(a_strobe_one, clk, rst_n, result_valid, !result_valid, "result strobe longer than one cycle")
    `RBFK_ASSERT_NXT(a_query_busy, clk, rst_n, start && !busy && cmd == CMD_QUERY && last, busy, "query end did not start a walk")
    `RBFK_ASSERT_IMP(a_walk_range, clk, rst_n, state_reg == ST_ISSUE, NCW'(c_reg) < nc_eff, "center walk past active count")
    `RBFK_ASSERT_NXT(a_drain_exit, clk, rst_n, state_reg == ST_DRAIN, state_reg == ST_DRAIN || state_reg == ST_DONE, "drain left early")

endmodule

>>> design/rbfk_dp.sv
// ---------------------------------------------------------------------------
// rbfk_dp
// stores, distance pipeline, exp table, weighted saturating accumulator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbfk_dp
    import rbfk_pkg::*;
#(
    parameter int MAX_CENTERS     = DEF_MAX_CENTERS,
    parameter int MAX_DIM         = DEF_MAX_DIM,
    parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  rbfk_ctl_t                    ctl,
    input  logic [(MAX_CENTERS > 1 ? $clog2(MAX_CENTERS) : 1)-1:0] c_idx,
    input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0]         j_idx,
    input  logic [$clog2(EXP_TABLE_DEPTH)-1:0]                     tab_addr,
    input  logic [1:0]                   cmd,
    input  logic [5:0]                   center_index,
    input  logic [3:0]                   coord_index,
    input  logic signed [COORD_W-1:0]    coord_value,
    input  logic signed [WEIGHT_W-1:0]   weight_value,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DAT_W-1:0]         cfg_data,
    output rbfk_stat_t                   stat,
    output logic signed [SCORE_W-1:0]    score,
    output logic                         class_positive,
    output logic                         saturated
);

    localparam int CIW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int JW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int TAW = $clog2(EXP_TABLE_DEPTH);
    localparam int CD  = MAX_CENTERS * MAX_DIM;
    localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
    localparam int DW  = 33 + $clog2(MAX_DIM);
    localparam int PHW = GAMMA_W + DW - 24;
    localparam int XW  = GAMMA_W + DW;

    localparam logic signed [SCORE_W+1:0] ACC_HI = 42'sh7F_FFFF_FFFF;
    localparam logic signed [SCORE_W+1:0] ACC_LO = -ACC_HI - 42'sd1;

    // configuration
    logic [GAMMA_W-1:0] gamma_reg;
    logic [NC_W-1:0]    nc_reg;
    logic [DIM_W-1:0]   dim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RST;
            nc_reg    <= NC_RST;
            dim_reg   <= DIM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAMMA:       gamma_reg <= cfg_data;
                REG_NUM_CENTERS: nc_reg    <= cfg_data[NC_W-1:0];
                REG_DIMENSION:   dim_reg   <= cfg_data[DIM_W-1:0];
                default:         ;
            endcase
        end
    end

    assign stat.num_centers = nc_reg;
    assign stat.dimension   = dim_reg;

    // stores
    logic signed [COORD_W-1:0]  center_mem [CD];
    logic signed [WEIGHT_W-1:0] weight_mem [MAX_CENTERS];
    logic signed [COORD_W-1:0]  query_mem  [MAX_DIM];
    logic [K_W-1:0]             tab_mem    [EXP_TABLE_DEPTH];

    logic           ci_ok, di_ok;
    logic [CAW-1:0] wr_caddr, rd_caddr;

    assign ci_ok    = int'(center_index) < MAX_CENTERS;
    assign di_ok    = int'(coord_index) < MAX_DIM;
    assign wr_caddr = CAW'(int'(center_index) * MAX_DIM + int'(coord_index));
    assign rd_caddr = CAW'(int'(c_idx) * MAX_DIM + int'(j_idx));

    logic signed [COORD_W-1:0]  cd_reg, qd_reg;
    logic signed [WEIGHT_W-1:0] wd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load && cmd == CMD_CENTER && ci_ok && di_ok)
            center_mem[wr_caddr] <= coord_value;
        cd_reg <= center_mem[rd_caddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && cmd == CMD_WEIGHT && ci_ok)
            weight_mem[CIW'(center_index)] <= weight_value;
        wd_reg <= weight_mem[c_idx];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && cmd == CMD_QUERY && di_ok)
            query_mem[JW'(coord_index)] <= coord_value;
        qd_reg <= query_mem[j_idx];
    end

    // exp table fill: t(i+1) = (t(i) * r + 2^31) >> 32
    logic [32:0]    t_reg;
    logic [64:0]    t_prod;
    logic [K_W-1:0] k_fill;

    assign t_prod = 65'(t_reg) * 65'(EXP_STEP_Q32);
    assign k_fill = K_W'((t_reg + 33'd32768) >> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_reg <= 33'h1_0000_0000;
        else if (ctl.tab_we)
            t_reg <= 33'((t_prod + 65'h8000_0000) >> 32);
    end

    // pipeline control bits
    logic s1_v, s1_first, s1_last, s1_zero;
    logic s2_v, s2_first, s2_last;
    logic s3_v, s4_v, s5_v, s6_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v <= 1'b0;
            s2_v <= 1'b0;
            s3_v <= 1'b0;
            s4_v <= 1'b0;
            s5_v <= 1'b0;
            s6_v <= 1'b0;
        end
        else
        begin
            s1_v <= ctl.issue;
            s2_v <= s1_v;
            s3_v <= s2_v && s2_last;
            s4_v <= s3_v;
            s5_v <= s4_v;
            s6_v <= s5_v;
        end
    end

    // squared difference
    logic signed [COORD_W:0]     diff;
    logic signed [2*COORD_W+1:0] sq_full;
    logic [31:0]                 sq_reg;
    logic signed [WEIGHT_W-1:0]  w2_reg, w3_reg, w4_reg, w5_reg;

    assign diff    = (COORD_W+1)'(qd_reg) - (COORD_W+1)'(cd_reg);
    assign sq_full = diff * diff;

    always_ff @(posedge clk)
    begin
        s1_first <= ctl.first_coord;
        s1_last  <= ctl.last_coord;
        s1_zero  <= ctl.zero_dist;
        s2_first <= s1_first;
        s2_last  <= s1_last;
        sq_reg   <= s1_zero ? 32'd0 : sq_full[31:0];
        w2_reg   <= wd_reg;
        w3_reg   <= w2_reg;
        w4_reg   <= w3_reg;
        w5_reg   <= w4_reg;
    end

    // distance sum, cleared on each center's first coordinate
    logic [DW-1:0] dist_reg;

    always_ff @(posedge clk)
    begin
        if (s2_v)
            dist_reg <= (s2_first ? DW'(0) : dist_reg) + DW'(sq_reg);
    end

    // gamma * distance in two partial products
    logic [GAMMA_W+23:0] plo_reg;
    logic [PHW-1:0]      phi_reg;

    always_ff @(posedge clk)
    begin
        plo_reg <= (GAMMA_W+24)'(gamma_reg) * (GAMMA_W+24)'(dist_reg[23:0]);
        phi_reg <= PHW'(gamma_reg) * PHW'(dist_reg[DW-1:24]);
    end

    // table lookup, index rounded to nearest 1/64
    logic [XW-1:0]  x_arg, t_idx;
    logic [K_W-1:0] k_reg;
    logic           kv_reg;

    assign x_arg = XW'(plo_reg) + (XW'(phi_reg) << 24);
    assign t_idx = (x_arg + XW'(33554432)) >> 26;

    always_ff @(posedge clk)
    begin
        if (ctl.tab_we)
            tab_mem[tab_addr] <= k_fill;
        k_reg <= tab_mem[t_idx[TAW-1:0]];
    end

    always_ff @(posedge clk)
        kv_reg <= (t_idx < XW'(EXP_TABLE_DEPTH));

    // weight times kernel
    logic [K_W-1:0]      kern;
    logic signed [49:0]  prod_reg;

    assign kern = kv_reg ? k_reg : '0;

    always_ff @(posedge clk)
        prod_reg <= $signed(w5_reg) * $signed({1'b0, kern});

    // rounded term and saturating accumulate
    logic signed [49:0]        term;
    logic signed [SCORE_W+1:0] acc_sum;
    logic signed [SCORE_W-1:0] acc_reg;
    logic                      sat_reg;

    assign term    = (prod_reg + 50'sd32768) >>> 16;
    assign acc_sum = (SCORE_W+2)'(acc_reg) + (SCORE_W+2)'(term);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (ctl.acc_clear)
        begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (s6_v)
        begin
            if (acc_sum > ACC_HI)
            begin
                acc_reg <= ACC_HI[SCORE_W-1:0];
                sat_reg <= 1'b1;
            end
            else if (acc_sum < ACC_LO)
            begin
                acc_reg <= ACC_LO[SCORE_W-1:0];
                sat_reg <= 1'b1;
            end
            else
                acc_reg <= acc_sum[SCORE_W-1:0];
        end
    end

    assign score          = acc_reg;
    assign class_positive = (acc_reg > 0);
    assign saturated      = sat_reg;

endmodule

>>> design/rbf_kernel_inference.sv
// ---------------------------------------------------------------------------
// rbf_kernel_inference
// gaussian rbf network inference, fixed point, one score per query
// ---------------------------------------------------------------------------
// channel   direction  handshake                    payload
// item      in         start & !busy                cmd center_index coord_index
//                                                   coord_value weight_value last
// config    in         cfg_valid & cfg_ready        cfg_index cfg_data
// result    out        result_valid (one cycle)     score class_positive saturated
//
// load and query items are taken one per cycle while busy is low.
// a query end walks centers at one coordinate per cycle through the distance
// pipeline, then waits for it to drain before raising result_valid.
// after reset the exp table is filled while busy is high.
// result_valid is high for one cycle only; the receiver cannot stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbf_kernel_inference
    import rbfk_pkg::*;
#(
    parameter int MAX_CENTERS     = DEF_MAX_CENTERS,
    parameter int MAX_DIM         = DEF_MAX_DIM,
    parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 cmd,
    input  logic [5:0]                 center_index,
    input  logic [3:0]                 coord_index,
    input  logic signed [COORD_W-1:0]  coord_value,
    input  logic signed [WEIGHT_W-1:0] weight_value,
    input  logic                       last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DAT_W-1:0]       cfg_data,
    output logic                       result_valid,
    output logic signed [SCORE_W-1:0]  score,
    output logic                       class_positive,
    output logic                       saturated
);

    localparam int CIW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int JW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int TAW = $clog2(EXP_TABLE_DEPTH);

    rbfk_ctl_t      ctl;
    rbfk_stat_t     stat;
    logic [CIW-1:0] c_idx;
    logic [JW-1:0]  j_idx;
    logic [TAW-1:0] tab_addr;

    assign cfg_ready = 1'b1;

    rbfk_ctrl #(
        .MAX_CENTERS     (MAX_CENTERS),
        .MAX_DIM         (MAX_DIM),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .last         (last),
        .stat         (stat),
        .busy         (busy),
        .result_valid (result_valid),
        .ctl          (ctl),
        .c_idx        (c_idx),
        .j_idx        (j_idx),
        .tab_addr     (tab_addr)
    );

    rbfk_dp #(
        .MAX_CENTERS     (MAX_CENTERS),
        .MAX_DIM         (MAX_DIM),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .c_idx          (c_idx),
        .j_idx          (j_idx),
        .tab_addr       (tab_addr),
        .cmd            (cmd),
        .center_index   (center_index),
        .coord_index    (coord_index),
        .coord_value    (coord_value),
        .weight_value   (weight_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .stat           (stat),
        .score          (score),
        .class_positive (class_positive),
        .saturated      (saturated)
    );

endmodule

>>> tb/rbf_kernel_checker.sv
// ---------------------------------------------------------------------------
// rbf kernel checker
// watches the item, config and result channels of rbf_kernel_inference,
// predicts each query score from its own copy of the stores and registers,
// and compares every result field against the oldest prediction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbf_kernel_checker
    import rbfk_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [1:0]                 cmd,
    input  logic [5:0]                 center_index,
    input  logic [3:0]                 coord_index,
    input  logic signed [COORD_W-1:0]  coord_value,
    input  logic signed [WEIGHT_W-1:0] weight_value,
    input  logic                       last,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DAT_W-1:0]       cfg_data,
    input  logic                       result_valid,
    input  logic signed [SCORE_W-1:0]  score,
    input  logic                       class_positive,
    input  logic                       saturated,
    output int                         errors,
    output int                         pending
);

    localparam longint ACC_HI = 64'sd549755813887;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef struct {
        logic signed [SCORE_W-1:0] score;
        logic                      positive;
        logic                      clipped;
    } score_t;

    longint unsigned kern_tab [DEF_EXP_TABLE_DEPTH];

    logic signed [COORD_W-1:0]  center_mem [DEF_MAX_CENTERS][DEF_MAX_DIM];
    logic signed [WEIGHT_W-1:0] weight_mem [DEF_MAX_CENTERS];
    logic signed [COORD_W-1:0]  query_mem  [DEF_MAX_DIM];
    logic [GAMMA_W-1:0]         gamma_q;
    logic [NC_W-1:0]            centers_q;
    logic [DIM_W-1:0]           dim_q;
    score_t                     score_fifo [$];

    initial
    begin
        longint unsigned t;
        t = 64'd1 << 32;
        for (int i = 0; i < DEF_EXP_TABLE_DEPTH; i++)
        begin
            kern_tab[i] = (t + 64'd32768) >> 16;
            t = (t * longint'(EXP_STEP_Q32) + (64'd1 << 31)) >> 32;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        score_t          got;
        score_t          want;
        int              nc_eff;
        int              dim_eff;
        longint unsigned dist_acc;
        longint unsigned x;
        longint unsigned idx;
        longint          diff;
        longint          kern;
        longint          acc;
        if (!rst_n)
        begin
            gamma_q   <= GAMMA_RST;
            centers_q <= NC_RST;
            dim_q     <= DIM_RST;
            score_fifo.delete();
            pending   <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (score_fifo.size() == 0)
                    report_mismatch($sformatf("result with no query waiting, score %0d", score));
                else
                begin
                    want = score_fifo.pop_front();
                    if (score !== want.score)
                        report_mismatch($sformatf("score %0d, expected %0d", score, want.score));
                    if (class_positive !== want.positive)
                        report_mismatch($sformatf("class_positive %b, expected %b",
                                                  class_positive, want.positive));
                    if (saturated !== want.clipped)
                        report_mismatch($sformatf("saturated %b, expected %b",
                                                  saturated, want.clipped));
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAMMA:       gamma_q   <= cfg_data[GAMMA_W-1:0];
                    REG_NUM_CENTERS: centers_q <= cfg_data[NC_W-1:0];
                    REG_DIMENSION:   dim_q     <= cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end

            if (start && !busy)
            begin
                case (cmd)
                    CMD_CENTER: center_mem[center_index][coord_index] = coord_value;
                    CMD_WEIGHT: weight_mem[center_index] = weight_value;
                    CMD_QUERY:
                    begin
                        query_mem[coord_index] = coord_value;
                        if (last)
                        begin
                            nc_eff  = centers_q > DEF_MAX_CENTERS ? DEF_MAX_CENTERS : centers_q;
                            dim_eff = dim_q > DEF_MAX_DIM ? DEF_MAX_DIM : dim_q;
                            acc = 0;
                            want.clipped = 1'b0;
                            for (int c = 0; c < nc_eff; c++)
                            begin
                                dist_acc = 0;
                                for (int j = 0; j < dim_eff; j++)
                                begin
                                    diff = longint'(query_mem[j]) - longint'(center_mem[c][j]);
                                    dist_acc += longint'(diff * diff);
                                end
                                x    = dist_acc * longint'(gamma_q);
                                idx  = (x + (64'd1 << 25)) >> 26;
                                kern = idx < DEF_EXP_TABLE_DEPTH ? longint'(kern_tab[idx]) : 0;
                                acc += (longint'(weight_mem[c]) * kern + 32768) >>> 16;
                                if (acc > ACC_HI)
                                begin
                                    acc = ACC_HI;
                                    want.clipped = 1'b1;
                                end
                                if (acc < ACC_LO)
                                begin
                                    acc = ACC_LO;
                                    want.clipped = 1'b1;
                                end
                            end
                            want.score    = acc[SCORE_W-1:0];
                            want.positive = acc > 0;
                            score_fifo.push_back(want);
                        end
                    end
                    default: ;
                endcase
            end
            pending <= score_fifo.size();
        end
    end

endmodule

>>> tb/tb_rbf_kernel_inference.sv
// ---------------------------------------------------------------------------
// tb_rbf_kernel_inference
// drives load and query items through several register settings, with
// directed corner items first and then mostly well-formed random queries
// near stored centers; the checker predicts and compares every score
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rbf_kernel_inference;
    import rbfk_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS = 1600;
    localparam int STALL_LIMIT = 20000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [1:0]                 cmd = CMD_CENTER;
    logic [5:0]                 center_index = '0;
    logic [3:0]                 coord_index = '0;
    logic signed [COORD_W-1:0]  coord_value = '0;
    logic signed [WEIGHT_W-1:0] weight_value = '0;
    logic                       last = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = REG_GAMMA;
    logic [CFG_DAT_W-1:0]       cfg_data = '0;
    logic                       result_valid;
    logic signed [SCORE_W-1:0]  score;
    logic                       class_positive;
    logic                       saturated;
    int                         errors;
    int                         pending;

    // what the stimulus has written so far, so no query reads an empty entry
    bit                         center_ok [DEF_MAX_CENTERS][DEF_MAX_DIM];
    bit                         weight_ok [DEF_MAX_CENTERS];
    bit                         query_ok  [DEF_MAX_DIM];
    logic [COORD_W-1:0]         center_val [DEF_MAX_CENTERS][DEF_MAX_DIM];
    int                         nc_eff = 1;
    int                         dim_eff = 1;
    int                         items_sent = 0;
    int                         stall_cycles = 0;

    always #2 clk = ~clk;

    rbf_kernel_inference DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .center_index(center_index), .coord_index(coord_index),
        .coord_value(coord_value), .weight_value(weight_value), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .score(score),
        .class_positive(class_positive), .saturated(saturated)
    );

    rbf_kernel_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .center_index(center_index), .coord_index(coord_index),
        .coord_value(coord_value), .weight_value(weight_value), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .score(score),
        .class_positive(class_positive), .saturated(saturated),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("rbf_kernel_inference test failed");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] c, input logic [5:0] ci, input logic [3:0] di,
                             input logic [15:0] cv, input logic [31:0] wv, input logic l);
        int idle_pct;
        idle_pct = items_sent < TOTAL_ITEMS / 3 ? 27 : items_sent < 2 * TOTAL_ITEMS / 3 ? 49 : 0;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start        <= 1'b1;
        cmd          <= c;
        center_index <= ci;
        coord_index  <= di;
        coord_value  <= cv;
        weight_value <= wv;
        last         <= l;
        do @(posedge clk); while (busy);
        case (c)
            CMD_CENTER:
            begin
                center_ok[ci][di]  = 1'b1;
                center_val[ci][di] = cv;
            end
            CMD_WEIGHT: weight_ok[ci] = 1'b1;
            CMD_QUERY:  query_ok[di] = 1'b1;
            default: ;
        endcase
        if (c != CMD_UNUSED)
            items_sent++;
    endtask

    // wait for every score, then let the block settle before touching registers
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    function automatic logic [15:0] query_coord(input int j);
        int cc;
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default:
            begin
                if (nc_eff == 0)
                    return $urandom;
                cc = $urandom_range(nc_eff - 1);
                return center_val[cc][j] + 16'(($urandom & ((1 << $urandom_range(13)) - 1))
                                                - (1 << 11));
            end
        endcase
    endfunction

    task automatic fill_missing();
        for (int c = 0; c < nc_eff; c++)
        begin
            if (!weight_ok[c])
                send_item(CMD_WEIGHT, c, $urandom, $urandom, $urandom, $urandom);
            for (int j = 0; j < dim_eff; j++)
                if (!center_ok[c][j])
                    send_item(CMD_CENTER, c, j, $urandom, $urandom, $urandom);
        end
        for (int j = 0; j < dim_eff; j++)
            if (!query_ok[j])
                send_item(CMD_QUERY, $urandom, j, query_coord(j), $urandom, 1'b0);
    endtask

    task automatic run_phase(input logic [15:0] g, input int nc, input int dim, input int n);
        int target;
        int r;
        drain();
        write_reg(REG_GAMMA, g);
        write_reg(REG_NUM_CENTERS, ($urandom & 16'hff80) | nc[6:0]);
        write_reg(REG_DIMENSION, ($urandom & 16'hffe0) | dim[4:0]);
        cfg_valid <= 1'b0;
        nc_eff  = nc > DEF_MAX_CENTERS ? DEF_MAX_CENTERS : nc;
        dim_eff = dim > DEF_MAX_DIM ? DEF_MAX_DIM : dim;
        target = items_sent + n;
        while (items_sent < target)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                fill_missing();
                if (dim_eff == 0)
                    send_item(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, 1'b1);
                for (int j = 0; j < dim_eff; j++)
                    send_item(CMD_QUERY, $urandom, j, query_coord(j), $urandom, j == dim_eff - 1);
            end
            else if (r < 85)
                send_item($urandom_range(1) ? CMD_CENTER : CMD_WEIGHT, $urandom, $urandom,
                          $urandom, $urandom, $urandom);
            else if (r < 92)
                send_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (r < 96)
                send_item(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, 1'b0);
            else
            begin
                // query cut short: a lone last item over the stale buffer
                fill_missing();
                send_item(CMD_QUERY, $urandom, $urandom, query_coord(0), $urandom, 1'b1);
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one center, one coordinate, gamma 1.0
        send_item(CMD_WEIGHT, 0, 0, 0, 32'h7fffffff, 1'b1);
        send_item(CMD_CENTER, 0, 0, 16'h8000, 0, 1'b1);
        send_item(CMD_QUERY, 0, 0, 16'h7fff, 0, 1'b1);
        send_item(CMD_QUERY, 0, 0, 16'h8000, 0, 1'b1);
        send_item(CMD_WEIGHT, 0, 0, 0, 32'h80000000, 1'b0);
        send_item(CMD_QUERY, 63, 0, 16'h8000, 0, 1'b1);
        send_item(CMD_QUERY, 0, 0, 16'h8400, 0, 1'b1);
        send_item(CMD_QUERY, 0, 0, 16'hc000, 0, 1'b1);
        send_item(CMD_WEIGHT, 0, 0, 0, 32'h00010000, 1'b0);
        send_item(CMD_QUERY, 0, 0, 16'h8000, 0, 1'b1);
        send_item(CMD_WEIGHT, 0, 0, 0, 32'h00000000, 1'b0);
        send_item(CMD_QUERY, 0, 0, 16'h8000, 0, 1'b1);
        send_item(CMD_UNUSED, 6'h3f, 4'hf, 16'hffff, 32'hffffffff, 1'b1);
        send_item(CMD_CENTER, 63, 15, 16'h7fff, 32'hffffffff, 1'b1);
        send_item(CMD_WEIGHT, 63, 15, 16'hffff, 32'h7fffffff, 1'b1);
        send_item(CMD_QUERY, 63, 15, 16'h0000, 32'hffffffff, 1'b0);
        send_item(CMD_QUERY, 0, 15, 16'h1234, 0, 1'b1);

        run_phase(16'd256, 1, 1, 120);
        run_phase(16'd0, 3, 2, 120);
        run_phase(16'hffff, 2, 16, 100);
        run_phase(16'd64, 64, 16, 25);
        run_phase(16'd1000, 0, 4, 60);
        run_phase(16'd20, 127, 31, 25);
        run_phase(16'd300, 5, 0, 100);
        run_phase(16'd1, 4, 3, 100);
        while (items_sent < TOTAL_ITEMS)
            run_phase($urandom, $urandom_range(1, 8), $urandom_range(1, 6), 150);

        drain();
        if (errors == 0 && pending == 0)
            $display("rbf_kernel_inference test passed");
        else
            $display("rbf_kernel_inference test failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/rbfk_pkg.sv
design/rbfk_ctrl.sv
design/rbfk_dp.sv
design/rbf_kernel_inference.sv
tb/rbf_kernel_checker.sv
tb/tb_rbf_kernel_inference.sv
